### sv/xlfp_pkg.sv
// ----------------------------------------------------------------------------
// xlfp_pkg
// Shared types, codes and decode functions of the X-frame parser.
// ----------------------------------------------------------------------------
package xlfp_pkg;

  localparam int unsigned StoreDepth = 10;
  localparam int unsigned CountW     = 5;
  localparam int unsigned QueueDepth = 2;

  // Header bytes
  localparam logic [7:0] HdrTurnout   = 8'h43;
  localparam logic [7:0] HdrAccessory = 8'h44;
  localparam logic [7:0] HdrStatus    = 8'h61;
  localparam logic [7:0] HdrStChanged = 8'h62;
  localparam logic [7:0] HdrVersion   = 8'h63;
  localparam logic [7:0] HdrCvResult  = 8'h64;
  localparam logic [7:0] HdrStopped   = 8'h81;
  localparam logic [7:0] HdrLocoInfo  = 8'hef;
  localparam logic [7:0] HdrFirmware  = 8'hf3;

  // Second byte of status frames
  localparam logic [7:0] SubPowerOff  = 8'h00;
  localparam logic [7:0] SubPowerOn   = 8'h01;
  localparam logic [7:0] SubProgMode  = 8'h02;
  localparam logic [7:0] SubShort     = 8'h08;
  localparam logic [7:0] SubCvNackSc  = 8'h12;
  localparam logic [7:0] SubCvNack    = 8'h13;
  localparam logic [7:0] SubUnknown   = 8'h82;

  // Loco address keeps the low six bits of the first data byte
  localparam logic [7:0] LocoAddrMask = 8'h3f;

  typedef enum logic [3:0] {
    ClsNone       = 4'd0,
    ClsTurnout    = 4'd1,
    ClsAccessory  = 4'd2,
    ClsPowerOff   = 4'd3,
    ClsPowerOn    = 4'd4,
    ClsProgMode   = 4'd5,
    ClsShort      = 4'd6,
    ClsCvNackSc   = 4'd7,
    ClsCvNack     = 4'd8,
    ClsUnknownCmd = 4'd9,
    ClsStChanged  = 4'd10,
    ClsVersion    = 4'd11,
    ClsCvResult   = 4'd12,
    ClsStopped    = 4'd13,
    ClsLocoInfo   = 4'd14,
    ClsFirmware   = 4'd15
  } frame_class_e;

  typedef enum logic [1:0] {
    Steps14      = 2'd0,
    Steps28      = 2'd1,
    Steps128     = 2'd2,
    StepsUnknown = 2'd3
  } step_mode_e;

  // Step code in the low bits of the loco status byte
  localparam logic [2:0] StepCode14  = 3'd0;
  localparam logic [2:0] StepCode28  = 3'd2;
  localparam logic [2:0] StepCode128 = 3'd4;

  // One finished frame, bytes past the frame end already zeroed
  typedef struct packed {
    logic [StoreDepth-1:0][7:0] bytes;
    logic                       checksum_ok;
    logic                       long_frame;
  } frame_desc_t;

  typedef struct packed {
    logic push;
  } queue_wr_t;

  function automatic frame_class_e class_of(logic [7:0] hdr, logic [7:0] db0);
    frame_class_e cls;
    cls = ClsNone;
    case (hdr)
      HdrTurnout:   cls = ClsTurnout;
      HdrAccessory: cls = ClsAccessory;
      HdrStatus: begin
        case (db0)
          SubPowerOff: cls = ClsPowerOff;
          SubPowerOn:  cls = ClsPowerOn;
          SubProgMode: cls = ClsProgMode;
          SubShort:    cls = ClsShort;
          SubCvNackSc: cls = ClsCvNackSc;
          SubCvNack:   cls = ClsCvNack;
          SubUnknown:  cls = ClsUnknownCmd;
          default:     cls = ClsNone;
        endcase
      end
      HdrStChanged: cls = ClsStChanged;
      HdrVersion:   cls = ClsVersion;
      HdrCvResult:  cls = ClsCvResult;
      HdrStopped:   cls = ClsStopped;
      HdrLocoInfo:  cls = ClsLocoInfo;
      HdrFirmware:  cls = ClsFirmware;
      default:      cls = ClsNone;
    endcase
    return cls;
  endfunction

  function automatic step_mode_e steps_of(logic [2:0] code);
    step_mode_e s;
    case (code)
      StepCode14:  s = Steps14;
      StepCode28:  s = Steps28;
      StepCode128: s = Steps128;
      default:     s = StepsUnknown;
    endcase
    return s;
  endfunction

endpackage

### sv/xlfp_if.sv
// ----------------------------------------------------------------------------
// xlfp_in_if / xlfp_out_if
// Valid/ready channels carrying frame bytes in and parse results out.
// ----------------------------------------------------------------------------
interface xlfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface xlfp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  frame_class;
  logic        checksum_ok;
  logic [16:0] address_or_cv;
  logic [7:0]  state_or_value;
  logic        acc_data_ok;
  logic        loco_busy;
  logic [1:0]  step_mode;
  logic        dir_forward;
  logic [6:0]  loco_speed;
  logic        dual_traction;
  logic        search_active;
  logic [31:0] function_bits;

  modport source (
    output valid, frame_class, checksum_ok, address_or_cv, state_or_value, acc_data_ok,
           loco_busy, step_mode, dir_forward, loco_speed, dual_traction,
           search_active, function_bits,
    input  ready
  );
  modport sink (
    input  valid, frame_class, checksum_ok, address_or_cv, state_or_value, acc_data_ok,
           loco_busy, step_mode, dir_forward, loco_speed, dual_traction,
           search_active, function_bits,
    output ready
  );
endinterface

### sv/xbus_lan_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// xbus_lan_frame_parser_unit
// X-frame parser with XOR checksum check, classification and field decode.
// ----------------------------------------------------------------------------
// The unit takes one frame byte per cycle on in_i while the queue has room,
// header first and checksum last with last_byte set, and sustains one byte
// per clock across frame boundaries. On the last byte it delivers one result
// on out_o: the frame class, checksum status and the decoded turnout,
// accessory, CV or loco fields. The edge that takes the last byte writes the
// finished frame into a two-entry queue; it is decoded into the output
// register once that register is free or being drained. The queue and output
// register let intake run on while a result waits; intake stalls only when
// both queue entries and the output register are occupied.
module xbus_lan_frame_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  xlfp_in_if.sink    in_i,
  xlfp_out_if.source out_o
);
  import xlfp_pkg::*;

  queue_wr_t   wr;
  frame_desc_t desc_in;
  frame_desc_t desc_head;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;

  // Intake of byte requests
  xlfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .ready_o      (in_i.ready),
    .frame_byte_i (in_i.frame_byte),
    .last_byte_i  (in_i.last_byte),
    .queue_full_i (q_full),
    .wr_o         (wr),
    .desc_o       (desc_in)
  );

  // Decouple intake from decode
  xlfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .desc_i  (desc_in),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (q_pop),
    .desc_o  (desc_head)
  );

  // Decode and hold the result
  xlfp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .desc_i  (desc_head),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

endmodule

### sv/xlfp_front.sv
// ----------------------------------------------------------------------------
// xlfp_front
// Byte intake: running XOR, byte count and capture of the first ten bytes.
// Emits one frame descriptor on the marked last byte.
// ----------------------------------------------------------------------------
module xlfp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [7:0]            frame_byte_i,
  input  logic                  last_byte_i,
  input  logic                  queue_full_i,
  output xlfp_pkg::queue_wr_t   wr_o,
  output xlfp_pkg::frame_desc_t desc_o
);
  import xlfp_pkg::*;

  localparam logic [CountW-1:0] CountMax   = {CountW{1'b1}};
  localparam logic [CountW-1:0] CountStore = CountW'(StoreDepth);

  logic [CountW-1:0]          count_q, count_d;
  logic [7:0]                 xor_q, xor_d;
  logic [StoreDepth-1:0][7:0] store_q;
  logic                       take;
  logic [7:0]                 xor_all;

  // Accept a request whenever the queue has room
  assign ready_o = !queue_full_i;
  assign take    = valid_i && ready_o;
  assign xor_all = xor_q ^ frame_byte_i;

  // Advance count and XOR; clear both at frame end
  always_comb begin
    count_d = count_q;
    xor_d   = xor_q;
    if (take) begin
      if (last_byte_i) begin
        count_d = '0;
        xor_d   = '0;
      end else begin
        xor_d = xor_all;
        if (count_q != CountMax) begin
          count_d = count_q + CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      xor_q   <= '0;
    end else begin
      count_q <= count_d;
      xor_q   <= xor_d;
    end
  end

  // Capture the first ten bytes of the frame
  always_ff @(posedge clk_i) begin
    if (take && count_q < CountStore) begin
      store_q[count_q[3:0]] <= frame_byte_i;
    end
  end

  // Build descriptor: stored bytes, the current byte, zero past the end
  always_comb begin
    for (int i = 0; i < StoreDepth; i++) begin
      if (CountW'(i) < count_q) begin
        desc_o.bytes[i] = store_q[i];
      end else if (CountW'(i) == count_q) begin
        desc_o.bytes[i] = frame_byte_i;
      end else begin
        desc_o.bytes[i] = '0;
      end
    end
    desc_o.checksum_ok = (xor_all == 8'h00);
    desc_o.long_frame  = (count_q >= CountStore);
  end

  assign wr_o.push = take && last_byte_i;

endmodule

### sv/xlfp_queue.sv
// ----------------------------------------------------------------------------
// xlfp_queue
// Two-entry queue of frame descriptors between intake and decode.
// ----------------------------------------------------------------------------
module xlfp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  xlfp_pkg::queue_wr_t   wr_i,
  input  xlfp_pkg::frame_desc_t desc_i,
  output logic                  full_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output xlfp_pkg::frame_desc_t desc_o
);
  import xlfp_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  frame_desc_t           mem_q [QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = wr_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign desc_o  = mem_q[rd_ptr_q];

  // Track occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  // Hold descriptor payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("queue occupancy past depth");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.push |-> !full_o)
    else $error("frame pushed into a full queue");

endmodule

### sv/xlfp_back.sv
// ----------------------------------------------------------------------------
// xlfp_back
// Frame decode: classifies a descriptor, extracts its fields and holds the
// result in an output register until taken.
// ----------------------------------------------------------------------------
module xlfp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  xlfp_pkg::frame_desc_t desc_i,
  output logic                  pop_o,
  xlfp_out_if.source            out_o
);
  import xlfp_pkg::*;

  logic         valid_q;
  frame_class_e cls;
  logic [7:0]   b0, b1, b2, b3, b4, b5;

  logic [3:0]  cls_d, cls_q;
  logic        ok_d, ok_q;
  logic [16:0] addr_d, addr_q;
  logic [7:0]  state_d, state_q;
  logic        dvalid_d, dvalid_q;
  logic        busy_d, busy_q;
  logic [1:0]  steps_d, steps_q;
  logic        dir_d, dir_q;
  logic [6:0]  speed_d, speed_q;
  logic        dtrac_d, dtrac_q;
  logic        search_d, search_q;
  logic [31:0] fn_d, fn_q;

  assign b0 = desc_i.bytes[0];
  assign b1 = desc_i.bytes[1];
  assign b2 = desc_i.bytes[2];
  assign b3 = desc_i.bytes[3];
  assign b4 = desc_i.bytes[4];
  assign b5 = desc_i.bytes[5];
  assign cls = desc_i.checksum_ok ? class_of(b0, b1) : ClsNone;

  // Take the next frame when the output register is free or being drained
  assign pop_o = !empty_i && (!valid_q || out_o.ready);

  // Extract class-specific fields, zero elsewhere
  always_comb begin
    cls_d    = cls;
    ok_d     = desc_i.checksum_ok;
    addr_d   = '0;
    state_d  = '0;
    dvalid_d = 1'b0;
    busy_d   = 1'b0;
    steps_d  = '0;
    dir_d    = 1'b0;
    speed_d  = '0;
    dtrac_d  = 1'b0;
    search_d = 1'b0;
    fn_d     = '0;
    case (cls)
      ClsTurnout: begin
        addr_d  = {1'b0, b1, b2};
        state_d = {6'b0, b3[1:0]};
      end
      ClsAccessory: begin
        addr_d   = {1'b0, b1, b2};
        state_d  = b3;
        dvalid_d = (b4 == 8'h00);
      end
      ClsCvResult: begin
        addr_d  = {1'b0, b2, b3} + 17'd1;
        state_d = b4;
      end
      ClsLocoInfo: begin
        addr_d   = {1'b0, b1 & LocoAddrMask, b2};
        busy_d   = b3[3];
        steps_d  = steps_of(b3[2:0]);
        dir_d    = b4[7];
        speed_d  = b4[6:0];
        dtrac_d  = b5[6];
        search_d = b5[5];
        fn_d     = {desc_i.long_frame ? desc_i.bytes[9][2:0] : 3'b000,
                    desc_i.bytes[8], desc_i.bytes[7], desc_i.bytes[6],
                    b5[3:0], b5[4]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Load the result register on pop
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cls_q    <= cls_d;
      ok_q     <= ok_d;
      addr_q   <= addr_d;
      state_q  <= state_d;
      dvalid_q <= dvalid_d;
      busy_q   <= busy_d;
      steps_q  <= steps_d;
      dir_q    <= dir_d;
      speed_q  <= speed_d;
      dtrac_q  <= dtrac_d;
      search_q <= search_d;
      fn_q     <= fn_d;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.frame_class    = cls_q;
  assign out_o.checksum_ok    = ok_q;
  assign out_o.address_or_cv  = addr_q;
  assign out_o.state_or_value = state_q;
  assign out_o.acc_data_ok    = dvalid_q;
  assign out_o.loco_busy      = busy_q;
  assign out_o.step_mode      = steps_q;
  assign out_o.dir_forward    = dir_q;
  assign out_o.loco_speed     = speed_q;
  assign out_o.dual_traction  = dtrac_q;
  assign out_o.search_active  = search_q;
  assign out_o.function_bits  = fn_q;

  a_class_needs_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && cls_q != ClsNone) |-> ok_q)
    else $error("frame classed despite bad checksum");

  a_bad_frame_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ok_q) |-> (addr_q == '0 && state_q == '0 && fn_q == '0))
    else $error("bad-checksum result carries field data");

  a_fn_only_loco : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && cls_q != ClsLocoInfo) |-> (fn_q == '0 && speed_q == '0))
    else $error("loco fields set on a non-loco frame");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the X-frame parser unit. Drives whole frames byte by
// byte on the input channel: first directed frames for every class and corner
// case, then random frames that are mostly well formed with random content.
// A scoreboard tracks the running XOR, the byte count and the stored bytes.
// It predicts each result and compares it field by field with the output.
// Both channels idle at random, except in one long stretch with no gaps.
// ----------------------------------------------------------------------------
module tb_top;
  import xlfp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // One decoded frame as it leaves the unit
  typedef struct packed {
    frame_class_e cls;
    logic         checksum_ok;
    logic [16:0]  address_or_cv;
    logic [7:0]   state_or_value;
    logic         acc_data_ok;
    logic         loco_busy;
    step_mode_e   steps;
    logic         dir_forward;
    logic [6:0]   loco_speed;
    logic         dual_traction;
    logic         search_active;
    logic [31:0]  function_bits;
  } frame_result_t;

  // --------------------------------------------------------------------------
  // Frame decode scoreboard
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic [7:0]        frame_bytes[StoreDepth];
    logic [CountW-1:0] byte_cnt;
    logic [7:0]        xor_acc;
    frame_result_t     expected_q[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       bad_sums;
    int unsigned       loco_frames;

    function new();
      byte_cnt = '0;
      xor_acc  = '0;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
      errors      = 0;
      checked     = 0;
      bad_sums    = 0;
      loco_frames = 0;
    endfunction

    // Bytes the frame did not reach read as zero
    function logic [7:0] byte_at(int unsigned pos, int unsigned len);
      if (pos >= len || pos >= StoreDepth) return 8'h00;
      return frame_bytes[pos];
    endfunction

    function frame_class_e classify(logic [7:0] hdr, logic [7:0] sub);
      case (hdr)
        HdrTurnout:   return ClsTurnout;
        HdrAccessory: return ClsAccessory;
        HdrStatus: begin
          case (sub)
            SubPowerOff: return ClsPowerOff;
            SubPowerOn:  return ClsPowerOn;
            SubProgMode: return ClsProgMode;
            SubShort:    return ClsShort;
            SubCvNackSc: return ClsCvNackSc;
            SubCvNack:   return ClsCvNack;
            SubUnknown:  return ClsUnknownCmd;
            default:     return ClsNone;
          endcase
        end
        HdrStChanged: return ClsStChanged;
        HdrVersion:   return ClsVersion;
        HdrCvResult:  return ClsCvResult;
        HdrStopped:   return ClsStopped;
        HdrLocoInfo:  return ClsLocoInfo;
        HdrFirmware:  return ClsFirmware;
        default:      return ClsNone;
      endcase
    endfunction

    // Track one accepted request; on the last byte queue the decoded frame
    function void note_byte(logic [7:0] b, logic last);
      int unsigned   len;
      frame_result_t r;
      logic [7:0]    b1, b2, b3, b4, b5, b9;
      if (byte_cnt < StoreDepth) frame_bytes[byte_cnt] = b;
      xor_acc = xor_acc ^ b;
      len = int'(byte_cnt) + 1;
      if (byte_cnt != '1) byte_cnt = byte_cnt + 1'b1;
      if (!last) return;

      r = '0;
      if (xor_acc == 8'h00) begin
        b1 = byte_at(1, len);
        b2 = byte_at(2, len);
        b3 = byte_at(3, len);
        b4 = byte_at(4, len);
        b5 = byte_at(5, len);
        r.checksum_ok = 1'b1;
        r.cls = classify(byte_at(0, len), b1);
        case (r.cls)
          ClsTurnout: begin
            r.address_or_cv  = {1'b0, b1, b2};
            r.state_or_value = {6'd0, b3[1:0]};
          end
          ClsAccessory: begin
            r.address_or_cv  = {1'b0, b1, b2};
            r.state_or_value = b3;
            r.acc_data_ok    = (b4 == 8'h00);
          end
          ClsCvResult: begin
            r.address_or_cv  = {1'b0, b2, b3} + 17'd1;
            r.state_or_value = b4;
          end
          ClsLocoInfo: begin
            loco_frames++;
            r.address_or_cv = {1'b0, b1 & LocoAddrMask, b2};
            r.loco_busy     = b3[3];
            case (b3[2:0])
              StepCode14:  r.steps = Steps14;
              StepCode28:  r.steps = Steps28;
              StepCode128: r.steps = Steps128;
              default:     r.steps = StepsUnknown;
            endcase
            r.dir_forward        = b4[7];
            r.loco_speed         = b4[6:0];
            r.dual_traction      = b5[6];
            r.search_active      = b5[5];
            r.function_bits[0]   = b5[4];
            r.function_bits[4:1] = b5[3:0];
            r.function_bits[12:5]  = byte_at(6, len);
            r.function_bits[20:13] = byte_at(7, len);
            r.function_bits[28:21] = byte_at(8, len);
            // Upper functions only in frames longer than the store
            if (len > StoreDepth) begin
              b9 = byte_at(9, len);
              r.function_bits[31:29] = b9[2:0];
            end
          end
          default: ;
        endcase
      end else begin
        bad_sums++;
      end
      expected_q.push_back(r);
      byte_cnt = '0;
      xor_acc  = '0;
    endfunction

    function void check_field(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      end
    endfunction

    // Compare one accepted result with the oldest pending frame
    function void check_result(frame_result_t act);
      frame_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with no frame pending, expected none, actual class %0d",
                 $time, act.cls);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      check_field("frame_class", 32'(e.cls), 32'(act.cls));
      check_field("checksum_ok", 32'(e.checksum_ok), 32'(act.checksum_ok));
      check_field("address_or_cv", 32'(e.address_or_cv), 32'(act.address_or_cv));
      check_field("state_or_value", 32'(e.state_or_value), 32'(act.state_or_value));
      check_field("acc_data_ok", 32'(e.acc_data_ok), 32'(act.acc_data_ok));
      check_field("loco_busy", 32'(e.loco_busy), 32'(act.loco_busy));
      check_field("step_mode", 32'(e.steps), 32'(act.steps));
      check_field("dir_forward", 32'(e.dir_forward), 32'(act.dir_forward));
      check_field("loco_speed", 32'(e.loco_speed), 32'(act.loco_speed));
      check_field("dual_traction", 32'(e.dual_traction), 32'(act.dual_traction));
      check_field("search_active", 32'(e.search_active), 32'(act.search_active));
      check_field("function_bits", e.function_bits, act.function_bits);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the unit
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  xlfp_in_if  in_if ();
  xlfp_out_if out_if ();

  xbus_lan_frame_parser_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  frame_scoreboard sb;
  int unsigned     idle_pct;
  int unsigned     bytes_sent;
  int unsigned     frames_sent;
  byte_q_t         frame_body;

  localparam logic [7:0] KnownHdrs[9] = '{HdrTurnout, HdrAccessory, HdrStatus, HdrStChanged,
                                          HdrVersion, HdrCvResult, HdrStopped, HdrLocoInfo,
                                          HdrFirmware};
  localparam logic [7:0] StatusSubs[7] = '{SubPowerOff, SubPowerOn, SubProgMode, SubShort,
                                           SubCvNackSc, SubCvNack, SubUnknown};

  // Offer one byte, idling at random first; return once it is accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.frame_byte <= b;
    in_if.last_byte  <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  // Append a good or a broken checksum, then send the whole frame
  task automatic send_frame(input byte_q_t body, input bit good);
    logic [7:0] x;
    x = 8'h00;
    foreach (body[i]) x = x ^ body[i];
    if (good) body.push_back(x);
    else body.push_back(x ^ 8'($urandom_range(1, 255)));
    foreach (body[i]) send_byte(body[i], i == body.size() - 1);
    frames_sent++;
  endtask

  // Fill the body up to a given length with random bytes
  task automatic pad_random(input int unsigned len);
    while (frame_body.size() < len) frame_body.push_back(8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Directed frames: every class, field extremes and the corner cases
  // --------------------------------------------------------------------------
  task automatic run_directed();
    frame_body = {HdrTurnout, 8'hff, 8'hff, 8'hff};               send_frame(frame_body, 1);
    frame_body = {HdrTurnout, 8'h00, 8'h00, 8'h00};               send_frame(frame_body, 1);
    frame_body = {HdrAccessory, 8'h12, 8'h34, 8'ha5, 8'h00};      send_frame(frame_body, 1);
    frame_body = {HdrAccessory, 8'hff, 8'hff, 8'hff, 8'h01};      send_frame(frame_body, 1);
    foreach (StatusSubs[i]) begin
      frame_body = {HdrStatus, StatusSubs[i]};
      send_frame(frame_body, 1);
    end
    // Status header with an unlisted second byte
    frame_body = {HdrStatus, 8'h05};                              send_frame(frame_body, 1);
    frame_body = {HdrStChanged, 8'h22};                           send_frame(frame_body, 1);
    frame_body = {HdrVersion, 8'h30, 8'h12};                      send_frame(frame_body, 1);
    // CV number carries past the 16-bit range into bit 16
    frame_body = {HdrCvResult, 8'h14, 8'hff, 8'hff, 8'hff};       send_frame(frame_body, 1);
    frame_body = {HdrCvResult, 8'h14, 8'h00, 8'h00, 8'h00};       send_frame(frame_body, 1);
    frame_body = {HdrStopped, 8'h00};                             send_frame(frame_body, 1);
    frame_body = {HdrFirmware, 8'h0a, 8'h01};                     send_frame(frame_body, 1);
    // Loco info long enough for the upper functions
    frame_body = {HdrLocoInfo, 8'hff, 8'hff, 8'h0f, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
    send_frame(frame_body, 1);
    // Loco info of exactly ten bytes: upper functions stay clear
    frame_body = {HdrLocoInfo, 8'hc0, 8'h01, 8'h04, 8'h80, 8'h50, 8'haa, 8'h55, 8'h0f};
    send_frame(frame_body, 1);
    // Short loco frame: missing bytes read as zero
    frame_body = {HdrLocoInfo, 8'h01, 8'h02, 8'h02};              send_frame(frame_body, 1);
    frame_body = {HdrLocoInfo, 8'h01, 8'h02, 8'h02, 8'h7f, 8'h3f}; send_frame(frame_body, 0);
    // Lone zero byte and a valid frame with an unknown header
    frame_body.delete();                                          send_frame(frame_body, 1);
    frame_body = {8'h00, 8'hff};                                  send_frame(frame_body, 1);
    // Long frame saturates the count
    frame_body = {HdrLocoInfo};
    pad_random(35);
    send_frame(frame_body, 1);
  endtask

  // --------------------------------------------------------------------------
  // Random frames, mostly well formed
  // --------------------------------------------------------------------------
  task automatic run_random(input int unsigned budget);
    int unsigned start_bytes;
    int unsigned kind;
    int unsigned len;
    logic [7:0]  hdr;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < budget) begin
      // Hold a long stretch with no idling on either side
      if (bytes_sent - start_bytes inside {[400:650]}) idle_pct = 0;
      else idle_pct = 34;
      kind = $urandom_range(0, 99);
      frame_body.delete();
      if (kind < 82) begin
        hdr = KnownHdrs[$urandom_range(0, 8)];
        frame_body.push_back(hdr);
        if (hdr == HdrStatus && $urandom_range(0, 3) != 0)
          frame_body.push_back(StatusSubs[$urandom_range(0, 6)]);
        case (hdr)
          HdrTurnout:   len = 4;
          HdrAccessory: len = 5;
          HdrVersion:   len = 3;
          HdrFirmware:  len = 3;
          HdrCvResult:  len = 5;
          HdrLocoInfo:  len = $urandom_range(6, 12);
          default:      len = 2;
        endcase
        // Some frames cut short or run long
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 12);
        pad_random(len);
        if (hdr == HdrAccessory && len > 4 && $urandom_range(0, 1) == 1) frame_body[4] = 8'h00;
        send_frame(frame_body, kind < 70);
      end else if (kind < 94) begin
        pad_random($urandom_range(0, 11));
        send_frame(frame_body, kind < 90);
      end else begin
        if ($urandom_range(0, 1) == 1) frame_body.push_back(HdrLocoInfo);
        pad_random($urandom_range(12, 40));
        send_frame(frame_body, $urandom_range(0, 3) != 0);
      end
    end
    idle_pct = 34;
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random stalls, check every accepted result
  // --------------------------------------------------------------------------
  initial begin
    frame_result_t act;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        act.cls            = frame_class_e'(out_if.frame_class);
        act.checksum_ok    = out_if.checksum_ok;
        act.address_or_cv  = out_if.address_or_cv;
        act.state_or_value = out_if.state_or_value;
        act.acc_data_ok    = out_if.acc_data_ok;
        act.loco_busy      = out_if.loco_busy;
        act.steps          = step_mode_e'(out_if.step_mode);
        act.dir_forward    = out_if.dir_forward;
        act.loco_speed     = out_if.loco_speed;
        act.dual_traction  = out_if.dual_traction;
        act.search_active  = out_if.search_active;
        act.function_bits  = out_if.function_bits;
        sb.check_result(act);
      end
      out_if.ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    idle_pct    = 34;
    bytes_sent  = 0;
    frames_sent = 0;
    in_if.valid      = 1'b0;
    in_if.frame_byte = 8'h00;
    in_if.last_byte  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(1050);
    in_if.valid <= 1'b0;

    // Drain the remaining results, then let the pipeline settle
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d frames (%0d bytes): %0d results checked, %0d bad checksums, %0d loco",
             frames_sent, bytes_sent, sb.checked, sb.bad_sums, sb.loco_frames);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Mismatches: %0d", sb.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding", sb.expected_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
